>>> src/trc_pkg.sv
package trc_pkg;

  localparam int unsigned NUM_PORTS  = 4;
  localparam int unsigned RING_DEPTH = 16;

  localparam int unsigned PortW   = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned HandleW = 32;
  localparam int unsigned TotalW  = 6;
  localparam int unsigned IdxW    = PortW + SlotW;
  localparam int unsigned Entries = NUM_PORTS * RING_DEPTH;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_REAP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NONE  = 2'd2,
    STAT_FREED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CANCEL,
    ST_SCAN,
    ST_DATA
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [PortW-1:0]   port;
    logic [SlotW-1:0]   slot;
    logic [HandleW-1:0] buffer_handle;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot_taken;
    logic [PortW-1:0]   freed_port;
    logic [HandleW-1:0] freed_handle;
    logic [TotalW-1:0]  total_pending;
    logic               last;
  } out_word_t;

endpackage

>>> src/tx_completion_ring_tracker.sv
// Transmit completion ring tracker: one pending-transmit ring per output port.
// Input channel (in_valid_i / in_stall_o, in_word_i) takes one command word:
// enqueue, cancel last enqueue, slot completed, or reap all ports.
// Output channel (out_valid_o / out_stall_i, out_word_o) returns result words;
// the final word of each command has last set.
// Enqueue and completion: result is registered on acceptance. Cancel: the
// handle RAM is read first, then ST_CANCEL registers the result. Reap: the
// scan visits ports in order; ST_SCAN passes an empty ring or reads its head
// flag and handle; ST_DATA frees a non-busy head and scans that ring again,
// or moves to the next port; the final word leaves when the scan ends.
// Commands are handled one at a time; the next is taken once the current one
// has placed its final word in the output register.
// Reset clears the ring pointers, counts and the pending total; the busy flag
// and handle stores are not cleared and need no clearing pass, as an entry is
// only read in a non-empty ring, at its head or newest entry, once enqueued.
// When the receiver stalls, the output word holds and the block stops at its
// next result, stalling the input side in turn.
module tx_completion_ring_tracker
  import trc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  state_e              state_q, state_d;
  logic [SlotW-1:0]    prod_q [NUM_PORTS];
  logic [SlotW-1:0]    prod_d [NUM_PORTS];
  logic [SlotW-1:0]    cons_q [NUM_PORTS];
  logic [SlotW-1:0]    cons_d [NUM_PORTS];
  logic [SlotW-1:0]    cnt_q  [NUM_PORTS];
  logic [SlotW-1:0]    cnt_d  [NUM_PORTS];
  logic [TotalW-1:0]   total_q, total_d;
  logic [PortW-1:0]    scan_q, scan_d;
  logic                scan_done;

  logic                hold_v_q, hold_v_d;
  logic [PortW-1:0]    hold_port_q, hold_port_d;
  logic [SlotW-1:0]    hold_slot_q, hold_slot_d;
  logic [TotalW-1:0]   hold_total_q, hold_total_d;
  logic [HandleW-1:0]  hold_handle_q, hold_handle_d;

  logic                out_valid_q;
  out_word_t           out_word_q, out_d;
  logic                out_load, out_free;

  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  logic [HandleW-1:0]  ram_rdata;

  logic                busy_we, busy_wdata, busy_rdata;
  logic [IdxW-1:0]     busy_waddr;

  logic [SlotW-1:0]    pr, pr_prev, cur;
  logic [TotalW-1:0]   total_dec;

  trc_ram #(
    .Width (HandleW),
    .Depth (Entries)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_word_i.buffer_handle),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  trc_ram #(
    .Width (1),
    .Depth (Entries)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (busy_waddr),
    .wdata_i (busy_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (busy_rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign total_dec = (total_q != '0) ? total_q - TotalW'(1) : total_q;
  assign pr        = prod_q[in_word_i.port];
  assign pr_prev   = (pr == '0) ? SlotW'(RING_DEPTH - 1) : pr - SlotW'(1);
  assign cur       = cons_q[scan_q];

  always_comb begin
    state_d       = state_q;
    prod_d        = prod_q;
    cons_d        = cons_q;
    cnt_d         = cnt_q;
    total_d       = total_q;
    scan_d        = scan_q;
    scan_done     = 1'b0;
    hold_v_d      = hold_v_q;
    hold_port_d   = hold_port_q;
    hold_slot_d   = hold_slot_q;
    hold_total_d  = hold_total_q;
    hold_handle_d = hold_handle_q;
    out_load      = 1'b0;
    out_d         = '0;
    in_stall_o    = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = {in_word_i.port, pr};
    ram_re        = 1'b0;
    ram_raddr     = {in_word_i.port, pr_prev};
    busy_we       = 1'b0;
    busy_wdata    = 1'b0;
    busy_waddr    = {in_word_i.port, in_word_i.slot};

    case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          out_d.last = 1'b1;
          case (in_word_i.command)
            CMD_ENQUEUE: begin
              out_load = 1'b1;
              if (cnt_q[in_word_i.port] < SlotW'(RING_DEPTH - 1)) begin
                ram_we                      = 1'b1;
                busy_we                     = 1'b1;
                busy_wdata                  = 1'b1;
                busy_waddr                  = {in_word_i.port, pr};
                prod_d[in_word_i.port]      = (pr == SlotW'(RING_DEPTH - 1)) ?
                                              '0 : pr + SlotW'(1);
                cnt_d[in_word_i.port]       = cnt_q[in_word_i.port] + SlotW'(1);
                total_d                     = total_q + TotalW'(1);
                out_d.status                = STAT_OK;
                out_d.slot_taken            = pr;
                out_d.total_pending         = total_q + TotalW'(1);
              end else begin
                out_d.status        = STAT_FULL;
                out_d.freed_port    = in_word_i.port;
                out_d.freed_handle  = in_word_i.buffer_handle;
                out_d.total_pending = total_q;
              end
            end
            CMD_CANCEL: begin
              if (cnt_q[in_word_i.port] != '0) begin
                ram_re                            = 1'b1;
                busy_we                           = 1'b1;
                busy_waddr                        = {in_word_i.port, pr_prev};
                prod_d[in_word_i.port]            = pr_prev;
                cnt_d[in_word_i.port]             = cnt_q[in_word_i.port] - SlotW'(1);
                total_d                           = total_dec;
                hold_port_d                       = in_word_i.port;
                hold_slot_d                       = pr_prev;
                hold_total_d                      = total_dec;
                state_d                           = ST_CANCEL;
              end else begin
                out_load            = 1'b1;
                out_d.status        = STAT_NONE;
                out_d.total_pending = total_q;
              end
            end
            CMD_COMPLETE: begin
              out_load            = 1'b1;
              busy_we             = 1'b1;
              out_d.status        = STAT_OK;
              out_d.total_pending = total_q;
            end
            CMD_REAP: begin
              scan_d   = '0;
              hold_v_d = 1'b0;
              state_d  = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_CANCEL: begin
        // read data holds (no read enable here) until the output register frees up
        if (out_free) begin
          out_load            = 1'b1;
          out_d.status        = STAT_OK;
          out_d.slot_taken    = hold_slot_q;
          out_d.freed_port    = hold_port_q;
          out_d.freed_handle  = ram_rdata;
          out_d.total_pending = hold_total_q;
          out_d.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (cnt_q[scan_q] != '0) begin
          // head flag and handle come back next cycle
          ram_re    = 1'b1;
          ram_raddr = {scan_q, cur};
          state_d   = ST_DATA;
        end else if (scan_q == PortW'(NUM_PORTS - 1)) begin
          scan_done = 1'b1;
        end else begin
          scan_d = scan_q + PortW'(1);
        end
      end

      ST_DATA: begin
        if (busy_rdata) begin
          if (scan_q == PortW'(NUM_PORTS - 1)) begin
            scan_done = 1'b1;
          end else begin
            scan_d  = scan_q + PortW'(1);
            state_d = ST_SCAN;
          end
        end else if (!hold_v_q || out_free) begin
          // previous freed entry goes out first, not last
          if (hold_v_q) begin
            out_load            = 1'b1;
            out_d.status        = STAT_FREED;
            out_d.freed_port    = hold_port_q;
            out_d.freed_handle  = hold_handle_q;
            out_d.total_pending = hold_total_q;
          end
          cons_d[scan_q] = (cur == SlotW'(RING_DEPTH - 1)) ? '0 : cur + SlotW'(1);
          cnt_d[scan_q]  = cnt_q[scan_q] - SlotW'(1);
          total_d        = total_dec;
          hold_port_d    = scan_q;
          hold_total_d   = total_dec;
          hold_handle_d  = ram_rdata;
          hold_v_d       = 1'b1;
          state_d        = ST_SCAN;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // end of reap: the held entry, or a nothing-freed word, goes out as last
    if (scan_done && out_free) begin
      out_load   = 1'b1;
      out_d.last = 1'b1;
      if (hold_v_q) begin
        out_d.status        = STAT_FREED;
        out_d.freed_port    = hold_port_q;
        out_d.freed_handle  = hold_handle_q;
        out_d.total_pending = hold_total_q;
      end else begin
        out_d.status        = STAT_NONE;
        out_d.total_pending = total_q;
      end
      hold_v_d = 1'b0;
      state_d  = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      scan_q      <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        prod_q[i] <= '0;
        cons_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      scan_q   <= scan_d;
      hold_v_q <= hold_v_d;
      prod_q   <= prod_d;
      cons_q   <= cons_d;
      cnt_q    <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_port_q   <= hold_port_d;
    hold_slot_q   <= hold_slot_d;
    hold_total_q  <= hold_total_d;
    hold_handle_q <= hold_handle_d;
    if (out_load) begin
      out_word_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> src/trc_ram.sv
module trc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/tb_tx_completion_ring_tracker.sv
module tb_tx_completion_ring_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import trc_pkg::*;

  typedef struct {
    in_word_t    w;
    int unsigned reps;
    bit          typed;
    out_word_t   want;
  } step_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // shadow of the ring state
  logic [SlotW-1:0]   ring_prod [NUM_PORTS];
  logic [SlotW-1:0]   ring_cons [NUM_PORTS];
  logic [SlotW-1:0]   ring_fill [NUM_PORTS];
  logic               slot_busy [Entries];
  logic [HandleW-1:0] slot_handle [Entries];
  logic [TotalW-1:0]  pending_cnt;

  out_word_t   owed_words[$];
  int unsigned bad_count;
  int unsigned cmds_taken;
  int unsigned burst_left;

  tx_completion_ring_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #2 clk_i = ~clk_i;

  function automatic out_word_t make_word(status_e s, logic [SlotW-1:0] sl,
                                          logic [PortW-1:0] pt, logic [HandleW-1:0] h,
                                          logic [TotalW-1:0] tot, logic lst);
    out_word_t r;
    r.status        = s;
    r.slot_taken    = sl;
    r.freed_port    = pt;
    r.freed_handle  = h;
    r.total_pending = tot;
    r.last          = lst;
    return r;
  endfunction

  function automatic step_t mk_step(cmd_e c, logic [PortW-1:0] pt, logic [SlotW-1:0] sl,
                                    logic [HandleW-1:0] h, int unsigned reps,
                                    int unsigned typed, out_word_t want);
    step_t s;
    s.w.command       = c;
    s.w.port          = pt;
    s.w.slot          = sl;
    s.w.buffer_handle = h;
    s.reps            = reps;
    s.typed           = (typed != 0);
    s.want            = want;
    return s;
  endfunction

  // Updates the shadow rings and queues the words the command should return.
  function automatic void apply_command(in_word_t w);
    logic [IdxW-1:0]  idx;
    logic [PortW-1:0] pp;
    logic [SlotW-1:0] sl;
    out_word_t        held;
    bit               have_held;
    have_held = 1'b0;
    held      = '0;
    case (w.command)
      CMD_ENQUEUE: begin
        if (ring_fill[w.port] < SlotW'(RING_DEPTH - 1)) begin
          sl               = ring_prod[w.port];
          idx              = {w.port, sl};
          slot_busy[idx]   = 1'b1;
          slot_handle[idx] = w.buffer_handle;
          ring_prod[w.port] = sl + SlotW'(1);
          ring_fill[w.port] = ring_fill[w.port] + SlotW'(1);
          pending_cnt       = pending_cnt + TotalW'(1);
          owed_words.push_back(make_word(STAT_OK, sl, '0, '0, pending_cnt, 1'b1));
        end else begin
          owed_words.push_back(make_word(STAT_FULL, '0, w.port, w.buffer_handle,
                                         pending_cnt, 1'b1));
        end
      end
      CMD_CANCEL: begin
        if (ring_fill[w.port] != '0) begin
          sl                = ring_prod[w.port] - SlotW'(1);
          idx               = {w.port, sl};
          ring_prod[w.port] = sl;
          slot_busy[idx]    = 1'b0;
          ring_fill[w.port] = ring_fill[w.port] - SlotW'(1);
          if (pending_cnt != '0) pending_cnt = pending_cnt - TotalW'(1);
          owed_words.push_back(make_word(STAT_OK, sl, w.port, slot_handle[idx],
                                         pending_cnt, 1'b1));
        end else begin
          owed_words.push_back(make_word(STAT_NONE, '0, '0, '0, pending_cnt, 1'b1));
        end
      end
      CMD_COMPLETE: begin
        slot_busy[{w.port, w.slot}] = 1'b0;
        owed_words.push_back(make_word(STAT_OK, '0, '0, '0, pending_cnt, 1'b1));
      end
      default: begin
        // one word per freed entry; the previous one is held back so the
        // final word can carry last
        for (int p = 0; p < NUM_PORTS; p++) begin
          pp = PortW'(p);
          while (ring_fill[pp] != '0 && !slot_busy[{pp, ring_cons[pp]}]) begin
            idx           = {pp, ring_cons[pp]};
            ring_cons[pp] = ring_cons[pp] + SlotW'(1);
            ring_fill[pp] = ring_fill[pp] - SlotW'(1);
            if (pending_cnt != '0) pending_cnt = pending_cnt - TotalW'(1);
            if (have_held) owed_words.push_back(held);
            held      = make_word(STAT_FREED, '0, pp, slot_handle[idx], pending_cnt, 1'b0);
            have_held = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          owed_words.push_back(held);
        end else begin
          owed_words.push_back(make_word(STAT_NONE, '0, '0, '0, pending_cnt, 1'b1));
        end
      end
    endcase
  endfunction

  // Offers one command word from a falling edge, returns at the falling edge
  // after it was taken. Bursts and gaps are handled here.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    apply_command(w);
    if (typed) begin
      void'(owed_words.pop_back());
      owed_words.push_back(want);
    end
    cmds_taken++;
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected result word st=%0d slot=%0d port=%0d h=%h tot=%0d last=%b",
                   $realtime, out_word.status, out_word.slot_taken, out_word.freed_port,
                   out_word.freed_handle, out_word.total_pending, out_word.last);
      end else begin
        want = owed_words.pop_front();
        if (out_word.status !== want.status || out_word.slot_taken !== want.slot_taken ||
            out_word.freed_port !== want.freed_port ||
            out_word.freed_handle !== want.freed_handle ||
            out_word.total_pending !== want.total_pending || out_word.last !== want.last) begin
          bad_count++;
          if (bad_count <= 10)
            $display({"%0t: result differs: exp st=%0d slot=%0d port=%0d h=%h tot=%0d last=%b",
                      " / got st=%0d slot=%0d port=%0d h=%h tot=%0d last=%b"},
                     $realtime, want.status, want.slot_taken, want.freed_port,
                     want.freed_handle, want.total_pending, want.last,
                     out_word.status, out_word.slot_taken, out_word.freed_port,
                     out_word.freed_handle, out_word.total_pending, out_word.last);
        end
      end
    end
  end

  // receiver: stall pattern redrawn for each random span, plus one long hold
  initial begin
    int unsigned mode;
    int unsigned span;
    bit          held;
    logic        s;
    held      = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (!held && cmds_taken >= 60) begin
          // long hold-off so the block backs up into the input side
          out_stall <= 1'b1;
          repeat (150) @(negedge clk_i);
          held = 1'b1;
        end
        case (mode)
          0:       s = 1'b0;
          1:       s = ($urandom_range(0, 3) == 0);
          2:       s = ($urandom_range(0, 3) != 0);
          default: s = ((k % 3) == 2);
        endcase
        out_stall <= s;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin
    step_t            dir_tab[$];
    in_word_t         w;
    logic [PortW-1:0] hot;
    logic [PortW-1:0] p;
    int unsigned      r;
    int unsigned      hot_next;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    bad_count   = 0;
    cmds_taken  = 0;
    burst_left  = 4;
    pending_cnt = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      ring_prod[i] = '0;
      ring_cons[i] = '0;
      ring_fill[i] = '0;
    end
    for (int i = 0; i < Entries; i++) begin
      slot_busy[i]   = 1'b0;
      slot_handle[i] = '0;
    end

    // reap and cancel on empty rings, stray completion
    dir_tab.push_back(mk_step(CMD_REAP, 2'd0, 4'd0, '0, 1, 1,
                              make_word(STAT_NONE, '0, '0, '0, 6'd0, 1'b1)));
    dir_tab.push_back(mk_step(CMD_CANCEL, 2'd0, 4'd0, '0, 1, 1,
                              make_word(STAT_NONE, '0, '0, '0, 6'd0, 1'b1)));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd3, 4'd15, 32'hFFFF_FFFF, 1, 1,
                              make_word(STAT_OK, '0, '0, '0, 6'd0, 1'b1)));
    dir_tab.push_back(mk_step(CMD_ENQUEUE, 2'd0, 4'd0, 32'h0000_0000, 1, 1,
                              make_word(STAT_OK, 4'd0, '0, '0, 6'd1, 1'b1)));
    dir_tab.push_back(mk_step(CMD_ENQUEUE, 2'd3, 4'd15, 32'hFFFF_FFFF, 1, 1,
                              make_word(STAT_OK, 4'd0, '0, '0, 6'd2, 1'b1)));
    dir_tab.push_back(mk_step(CMD_CANCEL, 2'd3, 4'd0, '0, 1, 1,
                              make_word(STAT_OK, 4'd0, 2'd3, 32'hFFFF_FFFF, 6'd1, 1'b1)));
    // head still busy, so nothing to free
    dir_tab.push_back(mk_step(CMD_REAP, 2'd0, 4'd0, '0, 1, 1,
                              make_word(STAT_NONE, '0, '0, '0, 6'd1, 1'b1)));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd0, 4'd0, '0, 1, 1,
                              make_word(STAT_OK, '0, '0, '0, 6'd1, 1'b1)));
    dir_tab.push_back(mk_step(CMD_REAP, 2'd0, 4'd0, '0, 1, 1,
                              make_word(STAT_FREED, '0, 2'd0, 32'h0000_0000, 6'd0, 1'b1)));
    // fill port 2 to depth-1, then one refused
    dir_tab.push_back(mk_step(CMD_ENQUEUE, 2'd2, 4'd0, 32'hA5A5_0000, 15, 0, '0));
    dir_tab.push_back(mk_step(CMD_ENQUEUE, 2'd2, 4'd9, 32'h5A5A_FFFF, 1, 1,
                              make_word(STAT_FULL, '0, 2'd2, 32'h5A5A_FFFF, 6'd15, 1'b1)));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd2, 4'd3, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_REAP, 2'd0, 4'd0, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd2, 4'd0, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd2, 4'd1, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd2, 4'd2, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_REAP, 2'd1, 4'd5, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_ENQUEUE, 2'd1, 4'd0, 32'h8000_0001, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_ENQUEUE, 2'd1, 4'd0, 32'h7FFF_FFFE, 1, 0, '0));
    // completion ahead of the head, then that entry is cancelled
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd1, 4'd1, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_CANCEL, 2'd1, 4'd0, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_COMPLETE, 2'd1, 4'd0, '0, 1, 0, '0));
    dir_tab.push_back(mk_step(CMD_REAP, 2'd3, 4'd15, 32'hFFFF_FFFF, 1, 0, '0));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      for (int k = 0; k < dir_tab[i].reps; k++)
        send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);

    hot      = 2'($urandom_range(0, 3));
    hot_next = $urandom_range(20, 50);
    for (int i = 0; i < 175; i++) begin
      if (i == hot_next) begin
        hot      = 2'($urandom_range(0, 3));
        hot_next = i + $urandom_range(20, 50);
      end
      if (i == 140) begin
        // let the block drain completely before carrying on
        in_valid <= 1'b0;
        @(negedge clk_i);
        while (owed_words.size() != 0) @(negedge clk_i);
      end
      p = ($urandom_range(0, 9) < 7) ? hot : 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      w.port          = p;
      w.slot          = 4'($urandom_range(0, 15));
      w.buffer_handle = $urandom;
      if (r < 45) begin
        w.command = CMD_ENQUEUE;
      end else if (r < 72) begin
        w.command = CMD_COMPLETE;
        // mostly the head slot, so reaps have something to free
        if (ring_fill[p] != '0)
          w.slot = ring_cons[p] + (($urandom_range(0, 2) == 0) ?
                   4'($urandom_range(0, ring_fill[p] - 1)) : 4'd0);
      end else if (r < 78) begin
        w.command = CMD_COMPLETE;
      end else if (r < 86) begin
        w.command = CMD_CANCEL;
      end else begin
        w.command = CMD_REAP;
      end
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (owed_words.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (bad_count == 0 && owed_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
